// ----- sv/qft_pkg.sv -----
// ---------------------------------------------------------------------------
// qft_pkg
// Shared types, register indexes and character constants for the
// quoted field tokenizer.
// ---------------------------------------------------------------------------
package qft_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_SEP_A       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SEP_B       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SEP_C       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SEP_D       = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MAX_FIELDS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TRIM_MODE   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_QUOTE_MODE  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_KEEP_QUOTES = 3'd7;

  // register reset values
  localparam logic [7:0] SEP_A_RST = 8'd32;

  // characters
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;

  typedef struct packed {
    logic [7:0] sep_char_a;
    logic [7:0] sep_char_b;
    logic [7:0] sep_char_c;
    logic [7:0] sep_char_d;
    logic [7:0] max_fields;
    logic       trim_mode;
    logic       quote_mode;
    logic       keep_quotes;
  } cfg_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       string_end;
  } out_item_t;

endpackage

// ----- sv/qft_in_if.sv -----
// ---------------------------------------------------------------------------
// qft_in_if
// Valid/ready channel carrying one input character transaction.
// ---------------------------------------------------------------------------
interface qft_in_if;
  logic               valid;
  logic               ready;
  qft_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/qft_out_if.sv -----
// ---------------------------------------------------------------------------
// qft_out_if
// Valid/ready channel carrying one token result transaction.
// ---------------------------------------------------------------------------
interface qft_out_if;
  logic               valid;
  logic               ready;
  qft_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/qft_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// qft_cfg_regs
// Configuration register file, write only, indexed by register number.
// ---------------------------------------------------------------------------
module qft_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qft_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qft_pkg::CfgDataW-1:0]  cfg_data_i,
  output qft_pkg::cfg_t                 cfg_o
);
  import qft_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SEP_A:       cfg_d.sep_char_a  = cfg_data_i;
        REG_SEP_B:       cfg_d.sep_char_b  = cfg_data_i;
        REG_SEP_C:       cfg_d.sep_char_c  = cfg_data_i;
        REG_SEP_D:       cfg_d.sep_char_d  = cfg_data_i;
        REG_MAX_FIELDS:  cfg_d.max_fields  = cfg_data_i;
        REG_TRIM_MODE:   cfg_d.trim_mode   = cfg_data_i[0];
        REG_QUOTE_MODE:  cfg_d.quote_mode  = cfg_data_i[0];
        REG_KEEP_QUOTES: cfg_d.keep_quotes = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      // separator a sits in the top byte, everything else clears
      cfg_q <= {SEP_A_RST, {($bits(cfg_t)-8){1'b0}}};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/qft_parser.sv -----
// ---------------------------------------------------------------------------
// qft_parser
// Tokenizer state and combinational step logic for one character.
// ---------------------------------------------------------------------------
module qft_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qft_pkg::cfg_t       cfg_i,
  input  logic                step_i,
  input  qft_pkg::in_item_t   item_i,
  output logic                res_valid_o,
  output qft_pkg::out_item_t  res_o
);
  import qft_pkg::*;

  localparam logic [1:0] PH_START    = 2'd0;
  localparam logic [1:0] PH_AFTER_BS = 2'd1;
  localparam logic [1:0] PH_PLAIN    = 2'd2;
  localparam logic [1:0] PH_QUOTED   = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic       qdouble_q, qdouble_d;
  logic       qclosed_q, qclosed_d;
  logic       esc_q, esc_d;
  logic [7:0] fields_q, fields_d;
  logic       rest_q, rest_d;

  logic [7:0] c;
  logic       is_sep, is_quote, at_limit, rest_now;
  logic [7:0] close_q_ch, esc_ch;

  assign c        = item_i.in_byte;
  assign is_sep   = (c != 8'd0) && ((c == cfg_i.sep_char_a) || (c == cfg_i.sep_char_b) ||
                                    (c == cfg_i.sep_char_c) || (c == cfg_i.sep_char_d));
  assign is_quote = (c == CH_SQUOTE) || (c == CH_DQUOTE);
  assign at_limit = (cfg_i.max_fields != 8'd0) &&
                    (({1'b0, fields_q} + 9'd1) >= {1'b0, cfg_i.max_fields});
  assign rest_now = rest_q | at_limit;
  assign close_q_ch = qdouble_q ? CH_DQUOTE : CH_SQUOTE;

  always_comb begin
    case (c)
      CH_N:    esc_ch = CH_LF;
      CH_R:    esc_ch = CH_CR;
      CH_T:    esc_ch = CH_TAB;
      default: esc_ch = c;
    endcase
  end

  always_comb begin
    logic do_begin, do_close;
    phase_d     = phase_q;
    qdouble_d   = qdouble_q;
    qclosed_d   = qclosed_q;
    esc_d       = esc_q;
    fields_d    = fields_q;
    rest_d      = rest_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    do_begin    = 1'b0;
    do_close    = 1'b0;

    if (item_i.end_of_string) begin
      res_valid_o     = 1'b1;
      res_o.token_end = !((phase_q == PH_START) && cfg_i.trim_mode);
      res_o.string_end = 1'b1;
      phase_d   = PH_START;
      qdouble_d = 1'b0;
      qclosed_d = 1'b0;
      esc_d     = 1'b0;
      fields_d  = '0;
      rest_d    = 1'b0;
    end else begin
      case (phase_q)
        PH_START: begin
          if (cfg_i.trim_mode && (c == CH_BSLASH)) begin
            rest_d  = rest_now;
            phase_d = PH_AFTER_BS;
          end else if (!(cfg_i.trim_mode && is_sep)) begin
            do_begin = 1'b1;
          end
        end
        PH_AFTER_BS: do_begin = 1'b1;
        PH_PLAIN: begin
          if (!rest_q && is_sep) begin
            do_close = 1'b1;
          end else begin
            res_valid_o      = 1'b1;
            res_o.out_byte   = c;
            res_o.byte_valid = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (esc_q) begin
            esc_d            = 1'b0;
            res_valid_o      = 1'b1;
            res_o.out_byte   = esc_ch;
            res_o.byte_valid = 1'b1;
          end else if (c == CH_BSLASH) begin
            esc_d = 1'b1;
          end else if (c == close_q_ch) begin
            qclosed_d = 1'b1;
            if (cfg_i.keep_quotes) begin
              res_valid_o      = 1'b1;
              res_o.out_byte   = c;
              res_o.byte_valid = 1'b1;
            end
          end else if (qclosed_q && is_sep) begin
            do_close = 1'b1;
          end else begin
            res_valid_o      = 1'b1;
            res_o.out_byte   = c;
            res_o.byte_valid = 1'b1;
          end
        end
        default: phase_d = PH_START;
      endcase

      // first byte of a token
      if (do_begin) begin
        rest_d = rest_now;
        if (!rest_now && cfg_i.quote_mode && is_quote) begin
          phase_d   = PH_QUOTED;
          qdouble_d = (c == CH_DQUOTE);
          qclosed_d = 1'b0;
          esc_d     = 1'b0;
          if (cfg_i.keep_quotes) begin
            res_valid_o      = 1'b1;
            res_o.out_byte   = c;
            res_o.byte_valid = 1'b1;
          end
        end else if (!rest_now && is_sep) begin
          do_close = 1'b1;
        end else begin
          phase_d          = PH_PLAIN;
          res_valid_o      = 1'b1;
          res_o.out_byte   = c;
          res_o.byte_valid = 1'b1;
        end
      end

      if (do_close) begin
        if (fields_q != 8'hff) begin
          fields_d = fields_q + 8'd1;
        end
        phase_d         = PH_START;
        qclosed_d       = 1'b0;
        esc_d           = 1'b0;
        res_valid_o     = 1'b1;
        res_o           = '0;
        res_o.token_end = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_START;
      qdouble_q <= 1'b0;
      qclosed_q <= 1'b0;
      esc_q     <= 1'b0;
      fields_q  <= '0;
      rest_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      qdouble_q <= qdouble_d;
      qclosed_q <= qclosed_d;
      esc_q     <= esc_d;
      fields_q  <= fields_d;
      rest_q    <= rest_d;
    end
  end

endmodule

// ----- sv/quoted_field_tokenizer.sv -----
// ---------------------------------------------------------------------------
// quoted_field_tokenizer
// Byte-stream tokenizer with configurable separators and quoted fields.
// ---------------------------------------------------------------------------
// Takes one character per cycle and gives at most one result per character:
// a token byte, a token end or the string end mark. Each transaction is
// held in an input register, stepped through the combinational parser and
// lands in an output register; throughput is one character per cycle
// while the output side keeps taking results; when the output stalls both
// registers fill and the input deasserts ready.
// Configuration registers may only be written while no transaction is in
// flight.
module quoted_field_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qft_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [qft_pkg::CfgDataW-1:0]  cfg_data_i,
  qft_in_if.sink                        in_i,
  qft_out_if.source                     out_o
);
  import qft_pkg::*;

  cfg_t      cfg;
  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;
  logic      advance;
  logic      res_valid;
  out_item_t res;

  qft_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // the parser steps whenever the output register can take its result
  assign advance = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  qft_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .step_i      (advance),
    .item_i      (in_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_o.ready) begin
      out_vld_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_byte_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.byte_valid && (out_q.token_end || out_q.string_end)))
    else $error("token byte combined with an end mark");

  a_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.byte_valid) |-> (out_q.out_byte == 8'd0))
    else $error("out_byte not zero on a mark-only result");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(in_q)))
    else $error("stalled input register lost its transaction");
`endif

endmodule

// ----- sim/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the quoted field tokenizer: a cycle-free model of
// the parser predicts every result, a monitor compares the results the block
// returns field by field, under random bursts, stalls and one long hold-off.
// ---------------------------------------------------------------------------
module testbench;
  import qft_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned SettleCycles  = 4;
  localparam int unsigned MaxReports    = 10;

  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_AFTER_BSLASH,
    SCAN_PLAIN,
    SCAN_QUOTED
  } scan_phase_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  qft_in_if  in_ch ();
  qft_out_if out_ch ();

  quoted_field_tokenizer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  // tokenizer model state
  cfg_t        model_cfg;
  scan_phase_e scan_phase;
  logic        in_dquote;
  logic        quote_done;
  logic        escape_armed;
  logic        rest_is_tail;
  logic [7:0]  fields_seen;

  out_item_t   expected_token_out[$];
  int unsigned failures;
  int unsigned items_sent;
  int unsigned idle_cycles;
  int unsigned burst_left;
  bit          in_fire;
  bit          out_fire;
  bit          tx_gaps;
  bit          rx_stalls;
  int unsigned rx_hold_len;
  int unsigned rx_hold_left;
  int unsigned rx_run;
  bit          rx_level;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------
  function automatic void clear_string_state();
    scan_phase   = SCAN_START;
    in_dquote    = 1'b0;
    quote_done   = 1'b0;
    escape_armed = 1'b0;
    fields_seen  = 8'd0;
    rest_is_tail = 1'b0;
  endfunction

  function automatic bit is_separator(input logic [7:0] c);
    if (c == 8'h00) return 1'b0;
    return c == model_cfg.sep_char_a || c == model_cfg.sep_char_b ||
           c == model_cfg.sep_char_c || c == model_cfg.sep_char_d;
  endfunction

  function automatic out_item_t char_result(input logic [7:0] c);
    out_item_t r;
    r            = '0;
    r.out_byte   = c;
    r.byte_valid = 1'b1;
    return r;
  endfunction

  function automatic out_item_t end_token();
    out_item_t r;
    if (fields_seen != 8'hff) fields_seen++;
    scan_phase   = SCAN_START;
    quote_done   = 1'b0;
    escape_armed = 1'b0;
    r            = '0;
    r.token_end  = 1'b1;
    return r;
  endfunction

  function automatic void note_field_limit();
    if (model_cfg.max_fields != 8'd0 &&
        {1'b0, fields_seen} + 9'd1 >= {1'b0, model_cfg.max_fields}) begin
      rest_is_tail = 1'b1;
    end
  endfunction

  function automatic bit open_token(input logic [7:0] c, output out_item_t r);
    r = '0;
    note_field_limit();
    if (!rest_is_tail && model_cfg.quote_mode && (c == CH_SQUOTE || c == CH_DQUOTE)) begin
      scan_phase   = SCAN_QUOTED;
      in_dquote    = (c == CH_DQUOTE);
      quote_done   = 1'b0;
      escape_armed = 1'b0;
      r            = char_result(c);
      return model_cfg.keep_quotes;
    end
    if (!rest_is_tail && is_separator(c)) begin
      r = end_token();
      return 1'b1;
    end
    scan_phase = SCAN_PLAIN;
    r          = char_result(c);
    return 1'b1;
  endfunction

  function automatic bit tokenize_step(input in_item_t it, output out_item_t r);
    logic [7:0] c;
    logic [7:0] q;
    c = it.in_byte;
    r = '0;
    if (it.end_of_string) begin
      r.token_end  = !(scan_phase == SCAN_START && model_cfg.trim_mode);
      r.string_end = 1'b1;
      clear_string_state();
      return 1'b1;
    end
    case (scan_phase)
      SCAN_START: begin
        if (model_cfg.trim_mode) begin
          if (c == CH_BSLASH) begin
            note_field_limit();
            scan_phase = SCAN_AFTER_BSLASH;
            return 1'b0;
          end
          if (is_separator(c)) return 1'b0;
        end
        return open_token(c, r);
      end
      SCAN_AFTER_BSLASH: return open_token(c, r);
      SCAN_PLAIN: begin
        if (!rest_is_tail && is_separator(c)) begin
          r = end_token();
          return 1'b1;
        end
        r = char_result(c);
        return 1'b1;
      end
      default: begin
        if (escape_armed) begin
          escape_armed = 1'b0;
          case (c)
            CH_N:    c = CH_LF;
            CH_R:    c = CH_CR;
            CH_T:    c = CH_TAB;
            default: ;
          endcase
          r = char_result(c);
          return 1'b1;
        end
        if (c == CH_BSLASH) begin
          escape_armed = 1'b1;
          return 1'b0;
        end
        q = in_dquote ? CH_DQUOTE : CH_SQUOTE;
        if (c == q) begin
          quote_done = 1'b1;
          r          = char_result(c);
          return model_cfg.keep_quotes;
        end
        if (quote_done && is_separator(c)) begin
          r = end_token();
          return 1'b1;
        end
        r = char_result(c);
        return 1'b1;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // result checking, sampled mid-cycle so both sides are settled
  // ---------------------------------------------------------------------
  task automatic check_result(input out_item_t got);
    out_item_t exp;
    if (expected_token_out.size() == 0) begin
      failures++;
      if (failures <= MaxReports)
        $display("unexpected result: byte %02h valid %0b tok_end %0b str_end %0b",
                 got.out_byte, got.byte_valid, got.token_end, got.string_end);
    end else begin
      exp = expected_token_out.pop_front();
      if (got.out_byte !== exp.out_byte || got.byte_valid !== exp.byte_valid ||
          got.token_end !== exp.token_end || got.string_end !== exp.string_end) begin
        failures++;
        if (failures <= MaxReports) begin
          $display("mismatch: expected byte %02h valid %0b tok_end %0b str_end %0b",
                   exp.out_byte, exp.byte_valid, exp.token_end, exp.string_end);
          $display("          got      byte %02h valid %0b tok_end %0b str_end %0b",
                   got.out_byte, got.byte_valid, got.token_end, got.string_end);
        end
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (out_fire) check_result(out_ch.data);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", idle_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: random ready runs, plus a long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        rx_hold_left = rx_hold_len;
        rx_hold_len  = 0;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (rx_run == 0) begin
          rx_run   = $urandom_range(1, 12);
          rx_level = !rx_stalls || ($urandom_range(0, 2) != 0);
        end
        rx_run--;
        out_ch.ready <= rx_level;
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------
  task automatic send_item(input in_item_t it);
    bit        took;
    out_item_t res;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_gaps && $urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do begin
      @(negedge clk_i);
      took = in_ch.ready;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
    if (tokenize_step(it, res)) expected_token_out.push_back(res);
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t it;
    it.in_byte       = c;
    it.end_of_string = 1'b0;
    send_item(it);
  endtask

  task automatic send_end();
    in_item_t it;
    it.in_byte       = 8'($urandom_range(0, 255));
    it.end_of_string = 1'b1;
    send_item(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // wait until every result is back and any trailing silent transaction is done
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_token_out.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    put_reg(REG_SEP_A, c.sep_char_a);
    put_reg(REG_SEP_B, c.sep_char_b);
    put_reg(REG_SEP_C, c.sep_char_c);
    put_reg(REG_SEP_D, c.sep_char_d);
    put_reg(REG_MAX_FIELDS, c.max_fields);
    // flag registers only look at bit 0
    put_reg(REG_TRIM_MODE, {7'($urandom_range(0, 127)), c.trim_mode});
    put_reg(REG_QUOTE_MODE, {7'($urandom_range(0, 127)), c.quote_mode});
    put_reg(REG_KEEP_QUOTES, {7'($urandom_range(0, 127)), c.keep_quotes});
    cfg_we <= 1'b0;
    model_cfg = c;
  endtask

  function automatic cfg_t make_cfg(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c, input logic [7:0] d,
                                    input logic [7:0] maxf, input bit trim,
                                    input bit quote, input bit keep);
    cfg_t r;
    r.sep_char_a  = a;
    r.sep_char_b  = b;
    r.sep_char_c  = c;
    r.sep_char_d  = d;
    r.max_fields  = maxf;
    r.trim_mode   = trim;
    r.quote_mode  = quote;
    r.keep_quotes = keep;
    return r;
  endfunction

  function automatic logic [7:0] random_sep_reg();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h20;
      2:       return $urandom_range(0, 1) ? 8'h2c : CH_TAB;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    logic [7:0] maxf;
    case ($urandom_range(0, 2))
      0:       maxf = 8'd0;
      1:       maxf = 8'($urandom_range(1, 4));
      default: maxf = 8'($urandom_range(0, 255));
    endcase
    return make_cfg(random_sep_reg(), random_sep_reg(), random_sep_reg(), random_sep_reg(),
                    maxf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
  endfunction

  // one of the active separators, a space when none is set
  function automatic logic [7:0] sep_char();
    logic [7:0]  seps [4];
    int unsigned k;
    seps[0] = model_cfg.sep_char_a;
    seps[1] = model_cfg.sep_char_b;
    seps[2] = model_cfg.sep_char_c;
    seps[3] = model_cfg.sep_char_d;
    k       = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++)
      if (seps[(k + i) % 4] != 8'h00) return seps[(k + i) % 4];
    return 8'h20;
  endfunction

  function automatic logic [7:0] any_char();
    case ($urandom_range(0, 11))
      0, 1, 2: return sep_char();
      3:       return $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
      4:       return CH_BSLASH;
      5: begin
        case ($urandom_range(0, 2))
          0:       return CH_N;
          1:       return CH_R;
          default: return CH_T;
        endcase
      end
      6:       return $urandom_range(0, 1) ? 8'h00 : 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_char();
    if ($urandom_range(0, 2) == 0) return any_char();
    return 8'($urandom_range(8'h61, 8'h7a));
  endfunction

  // a well-formed string: plain, quoted and backslash-led tokens
  task automatic send_string();
    int unsigned kind;
    logic [7:0]  q;
    repeat ($urandom_range(0, 5)) begin
      repeat ($urandom_range(0, 2)) send_char(sep_char());
      kind = $urandom_range(0, 3);
      if (kind == 1) begin
        q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
        send_char(q);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 4) == 0) send_char(CH_BSLASH);
          send_char(any_char());
        end
        if ($urandom_range(0, 7) != 0) send_char(q);
        repeat ($urandom_range(0, 2)) send_char(any_char());
      end else begin
        if (kind == 2) send_char(CH_BSLASH);
        repeat ($urandom_range(kind == 3 ? 0 : 1, 6)) send_char(plain_char());
      end
      if ($urandom_range(0, 3) != 0) send_char(sep_char());
    end
    send_end();
  endtask

  task automatic random_strings(input int unsigned n_items);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 4) != 0) begin
        send_string();
      end else begin
        // noise, including string ends at random points
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 15) == 0) send_end();
          else send_char($urandom_range(0, 1) ? any_char() : 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------
  task automatic test_reset_defaults();
    // space is the only separator after reset, zero byte is ordinary
    send_char(8'h00);
    send_char(" ");
    send_char(8'hff);
    send_end();
    send_end();
  endtask

  task automatic test_trim_and_quotes();
    drain();
    apply_config(make_cfg(" ", ",", 8'h00, 8'hff, 8'd0, 1'b1, 1'b1, 1'b0));
    send_end();
    // leading space skipped, backslash then comma gives an empty token,
    // quoted token with escapes, dropped extra quote, trailing separators
    send_text(" \\,\"a \\n\\t\\r\"\"  ");
    send_end();
    // escape left pending at the string end
    send_text("'\\");
    send_end();
  endtask

  task automatic test_field_limit();
    drain();
    apply_config(make_cfg(" ", ",", 8'h00, 8'h00, 8'd2, 1'b0, 1'b1, 1'b1));
    // second field takes the rest, quotes and separators are plain there
    send_text("x,',");
    send_end();
  endtask

  task automatic test_field_count_saturation();
    drain();
    apply_config(make_cfg(",", 8'h00, 8'h00, 8'h00, 8'd0, 1'b0, 1'b0, 1'b0));
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    repeat (300) send_char(",");
    send_char("z");
    send_end();
  endtask

  task automatic test_back_pressure();
    drain();
    apply_config(make_cfg(" ", ",", ";", CH_TAB, 8'd0, 1'b0, 1'b1, 1'b1));
    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    rx_hold_len = 300;
    repeat (8) send_string();
  endtask

  task automatic test_random_settings();
    drain();
    apply_config(make_cfg(" ", ",", ";", CH_TAB, 8'd0, 1'b1, 1'b1, 1'b0));
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    random_strings(300);
    // extreme register values, no idling on either side
    drain();
    apply_config(make_cfg(8'hff, 8'h01, 8'h00, 8'h80, 8'd255, 1'b1, 1'b1, 1'b1));
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    random_strings(200);
    drain();
    apply_config(make_cfg(" ", ",", 8'h00, 8'h00, 8'd1, 1'b0, 1'b1, 1'b1));
    tx_gaps   = 1'b1;
    rx_stalls = 1'b0;
    random_strings(150);
    repeat (4) begin
      drain();
      apply_config(random_cfg());
      tx_gaps   = 1'($urandom_range(0, 1));
      rx_stalls = 1'($urandom_range(0, 1));
      random_strings(230);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    failures      = 0;
    items_sent    = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    in_fire       = 1'b0;
    out_fire      = 1'b0;
    tx_gaps       = 1'b1;
    rx_stalls     = 1'b1;
    rx_hold_len   = 0;
    rx_hold_left  = 0;
    rx_run        = 0;
    rx_level      = 1'b1;
    model_cfg     = '0;
    model_cfg.sep_char_a = SEP_A_RST;
    clear_string_state();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_trim_and_quotes();
    test_field_limit();
    test_field_count_saturation();
    test_back_pressure();
    test_random_settings();
    drain();

    if (failures == 0 && expected_token_out.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failing transactions", failures);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/qft_pkg.sv
sv/qft_in_if.sv
sv/qft_out_if.sv
sv/qft_cfg_regs.sv
sv/qft_parser.sv
sv/quoted_field_tokenizer.sv
sim/testbench.sv
